// ===== rtl/slmp_pkg.sv =====
// Package for the station link mode policy block.
// Holds the event, mode, verdict, action and disconnect-kind codes, field widths,
// configuration register indices and register reset values. No dependencies.
package slmp_pkg;

    localparam int TIME_W = 48;
    localparam int WIN_W  = 32;
    localparam int CFG_IDX_W = 2;

    typedef logic [TIME_W-1:0] time_ms_t;
    typedef logic [WIN_W-1:0]  window_ms_t;

    typedef enum logic [2:0] {
        REQ_STEP           = 3'd0,
        REQ_BEGIN_VERIFY   = 3'd1,
        REQ_ATTEMPT_START  = 3'd2,
        REQ_CONNECTED      = 3'd3,
        REQ_ATTEMPT_FAILED = 3'd4,
        REQ_CREDS_CLEARED  = 3'd5,
        REQ_NOTE_RELEASE   = 3'd6,
        REQ_CLASSIFY       = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        MODE_ACTIVE    = 2'd0,
        MODE_VERIFYING = 2'd1,
        MODE_BOOT_HOLD = 2'd2,
        MODE_STANDBY   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        VERDICT_NONE    = 2'd0,
        VERDICT_PENDING = 2'd1,
        VERDICT_OK      = 2'd2,
        VERDICT_FAILED  = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_ATTEMPT = 2'd2
    } action_t;

    typedef enum logic {
        KIND_GENUINE = 1'b0,
        KIND_OWN     = 1'b1
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_IVAL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_DISC_WIN   = 2'd2;

    localparam window_ms_t VERIFY_WINDOW_RST = 32'd60000;
    localparam window_ms_t ATTEMPT_IVAL_RST  = 32'd30000;
    localparam window_ms_t OWN_DISC_WIN_RST  = 32'd5000;

endpackage

// ===== rtl/station_link_mode_policy_top.sv =====
// Top level of the station link mode policy block.
// Input register, one combinational decision stage, result register; uses slmp_pkg.
//
// Station link mode policy. Every transfer on the s_ channel is one event
// selected by s_req_type and stamped with a 48-bit millisecond time; every
// event yields exactly one result transfer on the m_ channel, in order.
// Timing: an accepted event waits in the input register until the
// decision stage reads it together with the policy state, updates the
// state and loads the result register; while the m_ side stalls, the
// event stays in the input register. One event per cycle is sustained:
// the decision stage (one 48-bit elapsed-time subtract and compare, one
// 48-bit saturating add and two compares) retires an event every cycle
// while the result register is empty or being drained.
// s_ready depends on m_ready through that stage. Configuration registers
// (verify window, attempt interval, own-disconnect window, 32 bits each)
// are written through the cfg_ port, which is always ready; index 3 is
// ignored. Write them only while no event is in flight. Elapsed time is
// zero when the clock appears to run backwards, and now plus the attempt
// interval saturates at 2^48-1.
module station_link_mode_policy_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // event channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_req_type,
    input  logic [slmp_pkg::TIME_W-1:0]    s_now_ms,
    input  logic                           s_wired_managed,
    input  logic                           s_boot_hold,
    input  logic                           s_arbitration_wants_sta,
    input  logic                           s_release_blocked,
    input  logic                           s_sta_associated,
    input  logic                           s_deadline_armed,
    input  logic                           s_creds_worth_retrying,
    input  logic                           s_was_associated,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_link_mode,
    output logic                           m_mode_changed,
    output logic [1:0]                     m_action,
    output logic                           m_disconnect_kind,
    output logic [1:0]                     m_verify_state,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [slmp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slmp_pkg::WIN_W-1:0]     cfg_data
);
    import slmp_pkg::*;

    // ---------------- configuration registers ----------------
    window_ms_t verify_window_reg;
    window_ms_t attempt_ival_reg;
    window_ms_t own_disc_win_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            verify_window_reg <= VERIFY_WINDOW_RST;
            attempt_ival_reg  <= ATTEMPT_IVAL_RST;
            own_disc_win_reg  <= OWN_DISC_WIN_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_VERIFY_WINDOW: verify_window_reg <= cfg_data;
                CFG_ATTEMPT_IVAL:  attempt_ival_reg  <= cfg_data;
                CFG_OWN_DISC_WIN:  own_disc_win_reg  <= cfg_data;
                default: ;  // unused index, write is dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    logic     in_valid_reg;
    req_t     in_req_reg;
    time_ms_t in_now_reg;
    logic     in_wired_reg, in_hold_reg, in_arb_reg, in_blocked_reg;
    logic     in_assoc_reg, in_armed_reg, in_creds_reg, in_was_assoc_reg;

    logic m_valid_reg;
    logic advance;      // decision stage retires the held event this cycle
    logic s_xfer;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_req_reg       <= req_t'(s_req_type);
            in_now_reg       <= s_now_ms;
            in_wired_reg     <= s_wired_managed;
            in_hold_reg      <= s_boot_hold;
            in_arb_reg       <= s_arbitration_wants_sta;
            in_blocked_reg   <= s_release_blocked;
            in_assoc_reg     <= s_sta_associated;
            in_armed_reg     <= s_deadline_armed;
            in_creds_reg     <= s_creds_worth_retrying;
            in_was_assoc_reg <= s_was_associated;
        end
    end

    // ---------------- policy state ----------------
    mode_t    cur_mode_reg,      cur_mode_next;
    verdict_t verdict_reg,       verdict_next;
    time_ms_t verify_start_reg,  verify_start_next;
    logic     attempt_seen_reg,  attempt_seen_next;
    logic     released_reg,      released_next;
    time_ms_t next_attempt_reg,  next_attempt_next;
    logic     own_drop_reg,      own_drop_next;
    time_ms_t release_time_reg,  release_time_next;

    // ---------------- decision stage ----------------
    // One shared elapsed-time unit: classify measures from the release time,
    // everything else from the verification start.
    time_ms_t      elapsed_start;
    window_ms_t    elapsed_win;
    logic [TIME_W:0] elapsed_diff;
    time_ms_t      elapsed;
    logic          elapsed_lt_win;
    logic [TIME_W:0] latest_sum;
    time_ms_t      latest;
    time_ms_t      nat_clamped;
    verdict_t      step_verdict;
    mode_t         step_mode;
    logic          is_hold_mode;

    mode_t   res_mode;
    logic    res_changed;
    action_t res_action;
    kind_t   res_kind;

    always_comb begin
        elapsed_start  = (in_req_reg == REQ_CLASSIFY) ? release_time_reg : verify_start_reg;
        elapsed_win    = (in_req_reg == REQ_CLASSIFY) ? own_disc_win_reg : verify_window_reg;
        elapsed_diff   = {1'b0, in_now_reg} - {1'b0, elapsed_start};
        elapsed        = elapsed_diff[TIME_W] ? '0 : elapsed_diff[TIME_W-1:0];
        elapsed_lt_win = elapsed < {{(TIME_W-WIN_W){1'b0}}, elapsed_win};

        // saturating now + interval
        latest_sum  = {1'b0, in_now_reg} + {{(TIME_W-WIN_W+1){1'b0}}, attempt_ival_reg};
        latest      = latest_sum[TIME_W] ? '1 : latest_sum[TIME_W-1:0];
        nat_clamped = (next_attempt_reg > latest) ? latest : next_attempt_reg;

        step_verdict = verdict_reg;
        if (verdict_reg == VERDICT_PENDING && !elapsed_lt_win) begin
            step_verdict = VERDICT_FAILED;
        end

        if (!in_wired_reg) begin
            step_mode = MODE_ACTIVE;
        end else if (step_verdict == VERDICT_PENDING) begin
            step_mode = MODE_VERIFYING;
        end else if (in_hold_reg) begin
            step_mode = MODE_BOOT_HOLD;
        end else if (in_arb_reg) begin
            step_mode = MODE_ACTIVE;
        end else if (in_blocked_reg && in_assoc_reg) begin
            step_mode = MODE_ACTIVE;
        end else begin
            step_mode = MODE_STANDBY;
        end
        is_hold_mode = (step_mode == MODE_BOOT_HOLD) || (step_mode == MODE_STANDBY);

        cur_mode_next     = cur_mode_reg;
        verdict_next      = verdict_reg;
        verify_start_next = verify_start_reg;
        attempt_seen_next = attempt_seen_reg;
        released_next     = released_reg;
        next_attempt_next = next_attempt_reg;
        own_drop_next     = own_drop_reg;
        release_time_next = release_time_reg;
        res_changed       = 1'b0;
        res_action        = ACT_NONE;
        res_kind          = KIND_GENUINE;

        unique case (in_req_reg)
            REQ_STEP: begin
                verdict_next  = step_verdict;
                cur_mode_next = step_mode;
                res_changed   = (step_mode != cur_mode_reg);
                if (in_wired_reg) begin
                    if (is_hold_mode) begin
                        if (!released_reg || in_assoc_reg || in_armed_reg) begin
                            res_action = ACT_RELEASE;
                        end
                        released_next = 1'b1;
                    end else begin
                        released_next     = 1'b0;
                        next_attempt_next = nat_clamped;
                        if (!in_assoc_reg && !in_armed_reg && in_creds_reg
                                && in_now_reg >= nat_clamped) begin
                            res_action        = ACT_ATTEMPT;
                            next_attempt_next = latest;
                        end
                    end
                end
            end
            REQ_BEGIN_VERIFY: begin
                verdict_next      = VERDICT_PENDING;
                verify_start_next = in_now_reg;
                attempt_seen_next = 1'b0;
            end
            REQ_ATTEMPT_START: begin
                if (verdict_reg == VERDICT_PENDING) attempt_seen_next = 1'b1;
            end
            REQ_CONNECTED: begin
                if (verdict_reg == VERDICT_PENDING) verdict_next = VERDICT_OK;
            end
            REQ_ATTEMPT_FAILED: begin
                if (verdict_reg == VERDICT_PENDING && attempt_seen_reg) begin
                    verdict_next = VERDICT_FAILED;
                end
            end
            REQ_CREDS_CLEARED: begin
                verdict_next      = VERDICT_NONE;
                attempt_seen_next = 1'b0;
            end
            REQ_NOTE_RELEASE: begin
                if (in_was_assoc_reg) begin
                    own_drop_next     = 1'b1;
                    release_time_next = in_now_reg;
                end
            end
            REQ_CLASSIFY: begin
                if (own_drop_reg) begin
                    own_drop_next = 1'b0;
                    if (elapsed_lt_win) res_kind = KIND_OWN;
                end
            end
            default: ;
        endcase

        res_mode = cur_mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_mode_reg     <= MODE_ACTIVE;
            verdict_reg      <= VERDICT_NONE;
            verify_start_reg <= '0;
            attempt_seen_reg <= 1'b0;
            released_reg     <= 1'b0;
            next_attempt_reg <= '0;
            own_drop_reg     <= 1'b0;
            release_time_reg <= '0;
        end else if (advance) begin
            cur_mode_reg     <= cur_mode_next;
            verdict_reg      <= verdict_next;
            verify_start_reg <= verify_start_next;
            attempt_seen_reg <= attempt_seen_next;
            released_reg     <= released_next;
            next_attempt_reg <= next_attempt_next;
            own_drop_reg     <= own_drop_next;
            release_time_reg <= release_time_next;
        end
    end

    // ---------------- result register ----------------
    mode_t    out_mode_reg;
    logic     out_changed_reg;
    action_t  out_action_reg;
    kind_t    out_kind_reg;
    verdict_t out_verdict_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_mode_reg    <= res_mode;
            out_changed_reg <= res_changed;
            out_action_reg  <= res_action;
            out_kind_reg    <= res_kind;
            out_verdict_reg <= verdict_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_link_mode       = out_mode_reg;
    assign m_mode_changed    = out_changed_reg;
    assign m_action          = out_action_reg;
    assign m_disconnect_kind = out_kind_reg;
    assign m_verify_state    = out_verdict_reg;

`ifndef SYNTHESIS
    // a release is only ordered in a held mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_action_reg == ACT_RELEASE |->
            (out_mode_reg == MODE_BOOT_HOLD || out_mode_reg == MODE_STANDBY))
        else $error("release action outside boot hold or standby");

    // an attempt is only started while the link is up or verifying
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_action_reg == ACT_ATTEMPT |->
            (out_mode_reg == MODE_ACTIVE || out_mode_reg == MODE_VERIFYING))
        else $error("attempt action outside active or verifying mode");

    // an own-release disconnect comes from a classify event, which is never a step
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_kind_reg == KIND_OWN |->
            (!out_changed_reg && out_action_reg == ACT_NONE))
        else $error("own disconnect reported together with step results");

    // a wired step outside the held modes keeps the next attempt time
    // within now plus the interval
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_req_reg == REQ_STEP && in_wired_reg && !is_hold_mode |=>
            next_attempt_reg <= $past(latest))
        else $error("next attempt time beyond the rate limit");

    // reset empties both pipeline registers
    assert property (@(posedge aclk)
        !aresetn |=> !in_valid_reg && !m_valid_reg)
        else $error("pipeline not empty after reset");
`endif

endmodule
